### hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared widths, defaults and the block header layout for the first-fit
// free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	// Default heap geometry.
	localparam int HEAP_UNITS_DEF = 4096;
	localparam int UNIT_BYTES_DEF = 8;

	// Field widths of the request and response channels.
	localparam int REQ_W     = 16;
	localparam int PAYLOAD_W = 12;
	localparam int COUNT_W   = 13;

	// Header word: block size in the low half, next-free offset in the high half.
	localparam int SIZE_W = 16;
	localparam int HDR_W  = 2 * SIZE_W;

	// Positions and sums of a position and an offset need one bit over a half word.
	localparam int POS_W  = SIZE_W + 1;
	localparam int NEED_W = REQ_W + 1;

	// Reciprocal used to turn a byte count into whole units.
	localparam int RECIP_SHIFT = 23;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	typedef struct packed {
		logic [SIZE_W-1:0] next;
		logic [SIZE_W-1:0] size;
	} hdr_t;

endpackage

### hw/rtl/ffa_if.sv
// ----------------------------------------------------------------------------
// First-fit allocator channels
// Valid/ready interfaces for allocation requests and their responses.
// ----------------------------------------------------------------------------
interface ffa_req_if;
	import ffa_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] request_bytes;

	modport source (output valid, output request_bytes, input ready);
	modport sink (input valid, input request_bytes, output ready);
endinterface

interface ffa_rsp_if;
	import ffa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 granted;
	logic [PAYLOAD_W-1:0] payload_unit;
	logic [COUNT_W-1:0]   units_taken;
	logic [COUNT_W-1:0]   used_units;

	modport source (output valid, output granted, output payload_unit,
		output units_taken, output used_units, input ready);
	modport sink (input valid, input granted, input payload_unit,
		input units_taken, input used_units, output ready);
endinterface

### hw/rtl/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// First-fit free-list allocator
// Serves allocation requests from a heap of fixed-size units by walking a
// free list of block headers held in an on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
// A request on req carries a payload size in bytes. It is rounded up to
// whole units and one header unit is added. The list is walked from the
// head, one header read per cycle, and the first block that is large enough
// serves the request, either whole or by carving units from its tail.
// The response on rsp gives the grant flag, the payload unit index, the
// units taken and the running count of used units.
// Steps: the byte count is scaled to units, each free block visited has its
// header read and compared, for a grant the new header is written, and the
// response register is loaded. A new request is taken at the earliest once
// the response register loads. The pace is set by the header walk through
// the single RAM read port: only one request is in flight, and req.ready is
// high only when idle.
// Reset: the list head lives in a register; after reset the block writes the
// header of the single free block into the RAM in its S_INIT state, and takes
// no request meanwhile. The used count starts at zero.
// Stall: a finished response waits in the output register; a new request can
// be taken meanwhile and holds its answer until the register is free.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
	parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
	parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ffa_req_if.sink   req,
	ffa_rsp_if.source rsp
);
	import ffa_pkg::*;

	localparam int AW     = $clog2(HEAP_UNITS);
	localparam int PROD_W = NEED_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));
	localparam logic [NEED_W-1:0] ROUND_UP = NEED_W'(UNIT_BYTES - 1);
	localparam logic [POS_W-1:0]  HEAP_END = POS_W'(HEAP_UNITS);
	localparam logic [SIZE_W-1:0] FIRST_SIZE = SIZE_W'(HEAP_UNITS - 1);
	localparam logic [AW-1:0]     FIRST_BLOCK = AW'(1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CALC,
		S_EVAL,
		S_FINISH,
		S_OUT
	} state_t;

	state_t              state_q;
	hdr_t                head_q;
	logic [PROD_W-1:0]   prod_q;
	logic [NEED_W-1:0]   need_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       prev_q;
	hdr_t                prev_w_q;
	logic [SIZE_W-1:0]   units_q;
	logic [POS_W-1:0]    at_q;
	logic [COUNT_W-1:0]  used_q;

	logic                res_granted_q;
	logic [PAYLOAD_W-1:0] res_payload_q;
	logic [COUNT_W-1:0]  res_units_q;
	logic [COUNT_W-1:0]  res_used_q;

	logic                rsp_valid_q;
	logic                rsp_granted_q;
	logic [PAYLOAD_W-1:0] rsp_payload_q;
	logic [COUNT_W-1:0]  rsp_units_q;
	logic [COUNT_W-1:0]  rsp_used_q;

	// RAM ports.
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	hdr_t                ram_wdata;
	logic [AW-1:0]       ram_raddr;
	hdr_t                ram_rdata;

	// Datapath of the walk.
	logic [NEED_W-1:0]   bytes_up;
	logic [PROD_W-1:0]   prod_c;
	logic [NEED_W-1:0]   need_c;
	logic [POS_W-1:0]    pos_ext;
	logic [NEED_W-1:0]   size_ext;
	logic                fits;
	logic [NEED_W-1:0]   units_c;
	logic                whole;
	logic [SIZE_W-1:0]   rest_c;
	logic [POS_W-1:0]    step_pos;
	logic [POS_W-1:0]    carve_at;
	logic [SIZE_W-1:0]   prev_next;
	hdr_t                prev_new;
	logic                head_bad;

	ffa_ram #(
		.WIDTH(HDR_W),
		.DEPTH(HEAP_UNITS)
	) u_heap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Byte count to units: round up, then multiply by the reciprocal.
	assign bytes_up = NEED_W'(req.request_bytes) + ROUND_UP;
	assign prod_c   = bytes_up * RECIP;
	assign need_c   = prod_q[RECIP_SHIFT +: NEED_W] + NEED_W'(1);
	assign head_bad = (head_q.next == '0) || (POS_W'(head_q.next) >= HEAP_END);

	// Compare and offset arithmetic on the header just read.
	always_comb begin
		pos_ext   = POS_W'(pos_q);
		size_ext  = NEED_W'(ram_rdata.size);
		fits      = size_ext >= need_q;
		units_c   = ((need_q + NEED_W'(1)) == size_ext) ? need_q + NEED_W'(1) : need_q;
		whole     = units_c == size_ext;
		rest_c    = ram_rdata.size - units_c[SIZE_W-1:0];
		step_pos  = pos_ext + POS_W'(ram_rdata.next);
		carve_at  = pos_ext + POS_W'(rest_c);
		prev_next = (ram_rdata.next != '0) ? prev_w_q.next + ram_rdata.next : '0;
		prev_new  = '{next: prev_next, size: prev_w_q.size};
	end

	// RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = ram_rdata;
		ram_raddr = pos_q;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = FIRST_BLOCK;
				ram_wdata = '{next: '0, size: FIRST_SIZE};
			end
			S_CALC: begin
				ram_raddr = head_q.next[AW-1:0];
			end
			S_EVAL: begin
				if (fits) begin
					if (whole) begin
						ram_we    = prev_q != '0;
						ram_waddr = prev_q;
						ram_wdata = prev_new;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = pos_q;
						ram_wdata = '{next: ram_rdata.next, size: rest_c};
					end
				end else begin
					ram_raddr = step_pos[AW-1:0];
				end
			end
			S_FINISH: begin
				ram_we    = at_q < HEAP_END;
				ram_waddr = at_q[AW-1:0];
				ram_wdata = '{next: '0, size: units_q};
			end
			S_IDLE, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer, walk registers and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			head_q      <= '{next: SIZE_W'(1), size: SIZE_W'(1)};
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The response register fills from S_OUT and empties when taken.
			if ((state_q == S_OUT) && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						prod_q  <= prod_c;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					need_q   <= need_c;
					pos_q    <= head_q.next[AW-1:0];
					prev_q   <= '0;
					prev_w_q <= head_q;
					if (head_bad) begin
						res_granted_q <= 1'b0;
						res_payload_q <= '0;
						res_units_q   <= '0;
						res_used_q    <= used_q;
						state_q       <= S_OUT;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (fits) begin
						units_q <= units_c[SIZE_W-1:0];
						if (whole) begin
							at_q <= pos_ext;
							if (prev_q == '0) begin
								head_q <= prev_new;
							end
						end else begin
							at_q <= carve_at;
						end
						state_q <= S_FINISH;
					end else if ((ram_rdata.next == '0) || (step_pos >= HEAP_END)) begin
						res_granted_q <= 1'b0;
						res_payload_q <= '0;
						res_units_q   <= '0;
						res_used_q    <= used_q;
						state_q       <= S_OUT;
					end else begin
						prev_q   <= pos_q;
						prev_w_q <= ram_rdata;
						pos_q    <= step_pos[AW-1:0];
					end
				end
				S_FINISH: begin
					if (at_q < HEAP_END) begin
						used_q        <= used_q + units_q[COUNT_W-1:0];
						res_granted_q <= 1'b1;
						res_payload_q <= PAYLOAD_W'(at_q + POS_W'(1));
						res_units_q   <= units_q[COUNT_W-1:0];
						res_used_q    <= used_q + units_q[COUNT_W-1:0];
					end else begin
						res_granted_q <= 1'b0;
						res_payload_q <= '0;
						res_units_q   <= '0;
						res_used_q    <= used_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_granted_q <= res_granted_q;
						rsp_payload_q <= res_payload_q;
						rsp_units_q   <= res_units_q;
						rsp_used_q    <= res_used_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = state_q == S_IDLE;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted      = rsp_granted_q;
	assign rsp.payload_unit = rsp_payload_q;
	assign rsp.units_taken  = rsp_units_q;
	assign rsp.used_units   = rsp_used_q;

	// The used count only moves when a new block header is committed.
	a_used_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_q) |-> $past(state_q == S_FINISH))
		else $error("used count changed outside a grant");

	// The list head is never written through the RAM.
	a_no_head_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && (state_q != S_INIT) |-> ram_waddr != '0)
		else $error("RAM write aimed at the list head");

	// A walk never stands on the head or outside the heap.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> (pos_q != '0) && (POS_W'(pos_q) < HEAP_END))
		else $error("walk position out of range");

	// A pending response is never overwritten while the receiver stalls.
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && rsp_valid_q && !rsp.ready |=> state_q == S_OUT)
		else $error("response register overwritten during a stall");

	// A taken request always enters the scaling step next.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == S_CALC)
		else $error("taken request did not start a walk");

endmodule

### hw/rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read data registered; a read of the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit allocator testbench
// Drives allocation requests into the first-fit free-list allocator and checks
// every response against a cycle-free model of the heap. The model keeps its
// own header image and used count. A short table of directed requests comes
// first, followed by random requests that fill the heap and a closing sequence
// that takes the last free block whole and then hits the empty list.
// ----------------------------------------------------------------------------
module tb;
	import ffa_pkg::*;

	localparam int HEAP = HEAP_UNITS_DEF;
	localparam int UNIT = UNIT_BYTES_DEF;
	localparam int RANDOM_REQUESTS = 1500;

	typedef struct packed {
		logic                 granted;
		logic [PAYLOAD_W-1:0] payload;
		logic [COUNT_W-1:0]   units;
		logic [COUNT_W-1:0]   used;
	} alloc_rsp_t;

	typedef struct {
		logic [REQ_W-1:0] bytes;
		bit               typed;
		alloc_rsp_t       want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	ffa_req_if req_if ();
	ffa_rsp_if rsp_if ();

	first_fit_free_list_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Model state: header image of the heap and the running used count.
	hdr_t               heap_img [HEAP];
	logic [COUNT_W-1:0] used_cnt;

	// Responses still owed by the block, oldest first.
	alloc_rsp_t grant_q [$];

	int  mismatches = 0;
	int  grants_seen = 0;
	int  refusals_seen = 0;
	bit  calm = 1'b0;

	// Directed requests. Rows with a typed answer follow from the reset state;
	// the others take their answer from the heap model.
	plan_row_t plan [15] = '{
		// Zero bytes on the fresh heap: the header lands on the last unit.
		'{16'd0,     1'b1, '{1'b1, 12'd0, 13'd1, 13'd1}},
		// Larger than the whole heap.
		'{16'hFFFF,  1'b1, '{1'b0, 12'd0, 13'd0, 13'd1}},
		'{16'h8000,  1'b1, '{1'b0, 12'd0, 13'd0, 13'd1}},
		// Needs 4096 units, more than the free block holds.
		'{16'd32760, 1'b1, '{1'b0, 12'd0, 13'd0, 13'd1}},
		'{16'd1,     1'b0, '0},
		'{16'd7,     1'b0, '0},
		'{16'd8,     1'b0, '0},
		'{16'd9,     1'b0, '0},
		'{16'd15,    1'b0, '0},
		'{16'd16,    1'b0, '0},
		'{16'd17,    1'b0, '0},
		'{16'd24,    1'b0, '0},
		'{16'd25,    1'b0, '0},
		'{16'd32752, 1'b0, '0},
		'{16'h7FFF,  1'b0, '0}
	};

	// Serve one request against the heap image: first fit, whole block when it fits
	// exactly or one unit would be left over, otherwise carve from the tail.
	function automatic alloc_rsp_t serve_request(input logic [REQ_W-1:0] bytes);
		alloc_rsp_t  r;
		int unsigned need, pos, prv, steps, off, size, nxt, units, at, rest;
		hdr_t        pw;
		need = (int'(bytes) + UNIT - 1) / UNIT + 1;
		r = '{granted: 1'b0, payload: '0, units: '0, used: used_cnt};
		off = heap_img[0].next;
		if (off == 0 || off >= HEAP)
			return r;
		pos = off;
		prv = 0;
		for (steps = 0; steps < HEAP; steps++) begin
			size = heap_img[pos].size;
			nxt = heap_img[pos].next;
			if (size >= need) begin
				units = need;
				if (units + 1 == size)
					units++;
				if (units == size) begin
					pw = heap_img[prv];
					heap_img[prv].next = (nxt != 0) ? SIZE_W'(pw.next + nxt) : '0;
					at = pos;
				end else begin
					rest = size - units;
					heap_img[pos].size = SIZE_W'(rest);
					at = pos + rest;
				end
				if (at >= HEAP)
					return r;
				heap_img[at] = '{next: '0, size: SIZE_W'(units)};
				used_cnt = used_cnt + COUNT_W'(units);
				r = '{granted: 1'b1, payload: PAYLOAD_W'(at + 1),
					units: COUNT_W'(units), used: used_cnt};
				return r;
			end
			if (nxt == 0)
				return r;
			prv = pos;
			pos = pos + nxt;
			if (pos >= HEAP)
				return r;
		end
		return r;
	endfunction

	// Size of the first block on the free list, zero when the list is empty.
	function automatic int unsigned first_free_size();
		int unsigned off;
		off = heap_img[0].next;
		return (off == 0 || off >= HEAP) ? 0 : heap_img[off].size;
	endfunction

	// Present one request, with an occasional idle gap first, and record the
	// expected answer once the block has taken it.
	task automatic send_request(input logic [REQ_W-1:0] bytes, input bit typed,
		input alloc_rsp_t want);
		alloc_rsp_t r;
		while (!calm && $urandom_range(0, 99) < 9) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.request_bytes <= bytes;
		do
			@(posedge clk);
		while (!req_if.ready);
		r = serve_request(bytes);
		grant_q.push_back(typed ? want : r);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("FAIL first_fit_free_list_allocator");
		$finish;
	end

	// Response side: random back-pressure and the field-by-field check.
	always @(posedge clk) begin
		alloc_rsp_t w;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (grant_q.size() == 0) begin
				$error("response with no request outstanding");
				mismatches++;
			end else begin
				w = grant_q.pop_front();
				if (rsp_if.granted !== w.granted) begin
					$error("granted: expected %0d, got %0d", w.granted, rsp_if.granted);
					mismatches++;
				end
				if (rsp_if.payload_unit !== w.payload) begin
					$error("payload_unit: expected %0d, got %0d", w.payload,
						rsp_if.payload_unit);
					mismatches++;
				end
				if (rsp_if.units_taken !== w.units) begin
					$error("units_taken: expected %0d, got %0d", w.units,
						rsp_if.units_taken);
					mismatches++;
				end
				if (rsp_if.used_units !== w.used) begin
					$error("used_units: expected %0d, got %0d", w.used, rsp_if.used_units);
					mismatches++;
				end
				if (w.granted)
					grants_seen++;
				else
					refusals_seen++;
			end
		end
		rsp_if.ready <= calm || $urandom_range(0, 99) >= 9;
	end

	// Stimulus.
	initial begin
		logic [REQ_W-1:0] bytes;
		int unsigned      left;
		int               pick;

		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.request_bytes <= '0;

		// Reset image of the heap: the head and one free block behind it.
		foreach (heap_img[i])
			heap_img[i] = '0;
		heap_img[0] = '{next: 16'd1, size: 16'd1};
		heap_img[1] = '{next: 16'd0, size: SIZE_W'(HEAP - 1)};
		used_cnt = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (plan[i])
			send_request(plan[i].bytes, plan[i].typed, plan[i].want);

		// Random requests: mostly small ones that keep the heap filling, some
		// medium ones, and oversize requests that must be refused. Once the
		// free block runs low only oversize requests are sent.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			calm = (n >= 500 && n < 800);
			pick = $urandom_range(0, 99);
			left = first_free_size();
			if (left < 40 || pick < 10)
				bytes = {1'b1, 15'($urandom)};
			else if (pick < 13)
				bytes = 16'($urandom_range(17, 200));
			else
				bytes = 16'($urandom_range(0, 16));
			send_request(bytes, 1'b0, '0);
		end
		calm = 1'b0;

		// Carve the free block down to three units, then ask for two so the
		// spare unit goes along and the block leaves the list.
		left = first_free_size();
		if (left > 3)
			send_request(16'((left - 4) * UNIT), 1'b0, '0);
		if (first_free_size() == 3)
			send_request(16'd8, 1'b0, '0);

		// The list is now empty: every request is refused.
		send_request(16'd0, 1'b0, '0);
		send_request(16'd1, 1'b0, '0);
		send_request(16'hFFFF, 1'b0, '0);
		req_if.valid <= 1'b0;

		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Checked %0d responses: %0d grants and %0d refusals, final used count %0d.",
			grants_seen + refusals_seen, grants_seen, refusals_seen, used_cnt);
		$display("Covered oversize and zero-byte requests, tail carving, whole-block take ",
			"and the empty list.");
		if (mismatches == 0)
			$display("PASS first_fit_free_list_allocator");
		else
			$display("FAIL first_fit_free_list_allocator");
		$finish;
	end

endmodule
